/* rtl/wrg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wrg_pkg;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 64;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int ADDR_W   = COL_W + ROW_W;
  localparam int CELLS    = MAX_COLS * MAX_ROWS;
  localparam int H_W      = 16;
  localparam int HMAX_W   = 15;
  localparam int GW_W     = 8;
  localparam int GH_W     = 7;
  localparam int SUM_W    = H_W + 2;
  localparam int DIV_W    = 20;
  localparam int Q_W      = 4;
  localparam int PROD_W   = 22;
  localparam int RECIP_W  = 23;
  localparam int RECIP_SH = 29;

  localparam logic [Q_W-1:0]     GLYPH_TOP = 4'd10;
  localparam logic [RECIP_W-1:0] RECIP_K   = 23'd5368710;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_HMIN   = 2'd0,
    CFG_HMAX   = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_DROP,
    S_WALK,
    S_DRAIN,
    S_RD0,
    S_RD1,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]            operation;
    logic [COL_W-1:0]      col;
    logic [ROW_W-1:0]      row;
    logic signed [H_W-1:0] cell_value;
    logic                  load_other;
    logic                  drop_enable;
  } in_word_t;

  typedef struct packed {
    logic signed [H_W-1:0] height;
    logic [2:0]            color_band;
    logic [Q_W-1:0]        glyph_level;
    logic                  drawable;
    logic                  done_res;
  } out_word_t;

  typedef struct packed {
    logic [HMAX_W-1:0] p90;
    logic [HMAX_W-1:0] p80;
    logic [HMAX_W-1:0] p60;
    logic [HMAX_W-1:0] p40;
    logic [HMAX_W-1:0] p20;
  } thresh_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [HMAX_W-1:0] divisor;
  } glyph_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] level;
  } glyph_rsp_t;

  function automatic logic signed [H_W-1:0] sat_h(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(signed'({1'b0, {(H_W-1){1'b1}}}));
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      return hi[H_W-1:0];
    end else if (v < lo) begin
      return lo[H_W-1:0];
    end
    return v[H_W-1:0];
  endfunction

  function automatic logic above(input logic signed [H_W-1:0] s,
                                 input logic [HMAX_W-1:0] p);
    logic signed [H_W:0] pe;
    logic signed [H_W:0] se;
    pe = signed'({2'b00, p});
    se = {s[H_W-1], s};
    return se > pe;
  endfunction

endpackage

`default_nettype wire

/* rtl/wrg_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module wrg_ram #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/wrg_thresh.sv */
`timescale 1ns / 1ps
`default_nettype none

module wrg_thresh (
  input  wire logic                            clk_i,
  input  wire logic [wrg_pkg::HMAX_W-1:0]      hmax_i,
  output wrg_pkg::thresh_t                     thresh_o
);

  import wrg_pkg::*;

  logic [PROD_W-1:0] y90_q, y80_q, y60_q, y40_q, y20_q;

  // x/100 as x*K >> 29, exact for x below 2^22
  function automatic logic [HMAX_W-1:0] div100(input logic [PROD_W-1:0] x);
    logic [PROD_W+RECIP_W-1:0] p;
    p = (PROD_W+RECIP_W)'(x) * (PROD_W+RECIP_W)'(RECIP_K);
    return p[RECIP_SH+HMAX_W-1:RECIP_SH];
  endfunction

  always_ff @(posedge clk_i) begin
    y90_q <= PROD_W'(hmax_i) * PROD_W'(90);
    y80_q <= PROD_W'(hmax_i) * PROD_W'(80);
    y60_q <= PROD_W'(hmax_i) * PROD_W'(60);
    y40_q <= PROD_W'(hmax_i) * PROD_W'(40);
    y20_q <= PROD_W'(hmax_i) * PROD_W'(20);
  end

  always_ff @(posedge clk_i) begin
    thresh_o.p90 <= div100(y90_q);
    thresh_o.p80 <= div100(y80_q);
    thresh_o.p60 <= div100(y60_q);
    thresh_o.p40 <= div100(y40_q);
    thresh_o.p20 <= div100(y20_q);
  end

endmodule

`default_nettype wire

/* rtl/wrg_glyph.sv */
`timescale 1ns / 1ps
`default_nettype none

module wrg_glyph (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire wrg_pkg::glyph_req_t req_i,
  output wrg_pkg::glyph_rsp_t      rsp_o
);

  import wrg_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [1:0]        k_q;
  logic [DIV_W-1:0]  rem_q;
  logic [Q_W-1:0]    quo_q;
  logic              sat_q;
  logic [HMAX_W-1:0] dvs_q;
  logic [DIV_W-1:0]  sh;
  logic              fits;

  assign sh   = DIV_W'(dvs_q) << k_q;
  assign fits = rem_q >= sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      k_q    <= 2'd3;
    end else if (busy_q) begin
      k_q <= k_q - 2'd1;
      if (k_q == 2'd0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend;
      quo_q <= '0;
      sat_q <= req_i.dividend >= {1'b0, req_i.divisor, 4'b0000};
      dvs_q <= req_i.divisor;
    end else if (busy_q && fits) begin
      rem_q      <= rem_q - sh;
      quo_q[k_q] <= 1'b1;
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.level = (sat_q || quo_q > GLYPH_TOP) ? GLYPH_TOP : quo_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q || $past(req_i.start))
    else $error("glyph done held");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rsp_o.level <= GLYPH_TOP)
    else $error("glyph level out of range");

  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && done_q))
    else $error("glyph busy and done");

endmodule

`default_nettype wire

/* rtl/water_ripple_grid_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

// Two-grid water ripple engine. Heights live in two 8192 x 16 single-port-read
// RAMs; a flag picks the current one. A load is one RAM write; a read is one
// RAM read followed by a 4-step glyph divider. In a step over a W x H grid in
// use, every interior cell needs its four neighbors from the previous-grid RAM,
// one per cycle through its single read port, while the current-grid RAM
// handles the cell's own read and write.
// No clearing pass after reset; cells must be loaded before they are read.
// A finished word waits in the output register while the next item is taken.
module water_ripple_grid_engine (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire wrg_pkg::in_word_t          in_word_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output wrg_pkg::out_word_t              out_word_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [1:0]                 cfg_index_i,
  input  wire logic [wrg_pkg::H_W-1:0]    cfg_data_i
);

  import wrg_pkg::*;

  state_e state_q, state_d;
  logic   flag_q, flag_d;

  logic signed [H_W-1:0] hmin_q;
  logic [HMAX_W-1:0]     hmax_q;
  logic [GW_W-1:0]       gw_q;
  logic [GH_W-1:0]       gh_q;
  logic [HMAX_W-1:0]     hm_eff;
  logic [GW_W-1:0]       cols_used;
  logic [GH_W-1:0]       rows_used;
  logic [COL_W-1:0]      last_i;
  logic [ROW_W-1:0]      last_j;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             drop_q, drop_d;
  logic             inside_q, inside_d;
  logic             in_acc, in_inside;
  op_e              in_op;

  logic [COL_W-1:0] i_q, i_d;
  logic [ROW_W-1:0] j_q, j_d;
  logic [1:0]       ph_q, ph_d;
  logic             dv_q;
  logic [1:0]       dph_q;
  logic [ADDR_W-1:0] daddr_q;
  logic signed [SUM_W-1:0] acc_q;
  logic signed [H_W-1:0]   curv_q;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] nv;

  logic signed [H_W-1:0] s_q, s_d;
  out_word_t             pend_q, pend_d;
  out_word_t             res_q;
  logic                  out_valid_q;
  logic                  res_load;

  logic              cur_we, prev_we, cur_re, prev_re;
  logic [ADDR_W-1:0] cur_waddr, prev_waddr, cur_raddr, prev_raddr;
  logic [H_W-1:0]    cur_wdata, prev_wdata, cur_rdata, prev_rdata;
  logic [H_W-1:0]    a_rdata, b_rdata;

  thresh_t    thr;
  glyph_req_t greq;
  glyph_rsp_t grsp;

  logic signed [H_W:0] rd_diff;
  logic                s_draw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hmin_q <= '0;
      hmax_q <= HMAX_W'(100);
      gw_q   <= GW_W'(MAX_COLS);
      gh_q   <= GH_W'(MAX_ROWS);
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_HMIN:   hmin_q <= cfg_data_i;
        CFG_HMAX:   hmax_q <= cfg_data_i[HMAX_W-1:0];
        CFG_WIDTH:  gw_q   <= cfg_data_i[GW_W-1:0];
        CFG_HEIGHT: gh_q   <= cfg_data_i[GH_W-1:0];
        default:    hmin_q <= hmin_q;
      endcase
    end
  end

  always_comb begin
    hm_eff = (hmax_q == '0) ? HMAX_W'(1) : hmax_q;
    if (gw_q < GW_W'(3)) begin
      cols_used = GW_W'(3);
    end else if (gw_q > GW_W'(MAX_COLS)) begin
      cols_used = GW_W'(MAX_COLS);
    end else begin
      cols_used = gw_q;
    end
    if (gh_q < GH_W'(3)) begin
      rows_used = GH_W'(3);
    end else if (gh_q > GH_W'(MAX_ROWS)) begin
      rows_used = GH_W'(MAX_ROWS);
    end else begin
      rows_used = gh_q;
    end
  end

  assign last_i = COL_W'(cols_used - GW_W'(2));
  assign last_j = ROW_W'(rows_used - GH_W'(2));

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_op      = op_e'(in_word_i.operation);
  assign in_inside  = ({1'b0, in_word_i.col} < cols_used) &&
                      ({1'b0, in_word_i.row} < rows_used);

  wrg_thresh u_thresh (
    .clk_i    (clk_i),
    .hmax_i   (hm_eff),
    .thresh_o (thr)
  );

  wrg_glyph u_glyph (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (greq),
    .rsp_o  (grsp)
  );

  assign cur_rdata  = flag_q ? b_rdata : a_rdata;
  assign prev_rdata = flag_q ? a_rdata : b_rdata;

  wrg_ram #(.DEPTH(CELLS), .WIDTH(H_W)) u_grid_a (
    .clk_i   (clk_i),
    .we_i    (flag_q ? prev_we : cur_we),
    .waddr_i (flag_q ? prev_waddr : cur_waddr),
    .wdata_i (flag_q ? prev_wdata : cur_wdata),
    .re_i    (flag_q ? prev_re : cur_re),
    .raddr_i (flag_q ? prev_raddr : cur_raddr),
    .rdata_o (a_rdata)
  );

  wrg_ram #(.DEPTH(CELLS), .WIDTH(H_W)) u_grid_b (
    .clk_i   (clk_i),
    .we_i    (flag_q ? cur_we : prev_we),
    .waddr_i (flag_q ? cur_waddr : prev_waddr),
    .wdata_i (flag_q ? cur_wdata : prev_wdata),
    .re_i    (flag_q ? cur_re : prev_re),
    .raddr_i (flag_q ? cur_raddr : prev_raddr),
    .rdata_o (b_rdata)
  );

  // new = floor(sum of neighbors / 2) - own
  assign sum = acc_q + SUM_W'(signed'(prev_rdata));
  assign nv  = SUM_W'(sum >>> 1) - SUM_W'(curv_q);

  assign rd_diff = {cur_rdata[H_W-1], cur_rdata} - {hmin_q[H_W-1], hmin_q};
  assign s_draw  = (s_q <= signed'({1'b0, hmax_q})) && (s_q >= hmin_q);

  always_comb begin
    state_d  = state_q;
    flag_d   = flag_q;
    col_d    = col_q;
    row_d    = row_q;
    drop_d   = drop_q;
    inside_d = inside_q;
    i_d      = i_q;
    j_d      = j_q;
    ph_d     = ph_q;
    s_d      = s_q;
    pend_d   = pend_q;
    res_load = 1'b0;

    cur_we     = 1'b0;
    cur_waddr  = {in_word_i.row, in_word_i.col};
    cur_wdata  = in_word_i.cell_value;
    prev_we    = 1'b0;
    prev_waddr = {in_word_i.row, in_word_i.col};
    prev_wdata = in_word_i.cell_value;
    cur_re     = 1'b0;
    cur_raddr  = {in_word_i.row, in_word_i.col};
    prev_re    = 1'b0;
    prev_raddr = {j_q, i_q - COL_W'(1)};

    greq.start    = 1'b0;
    greq.dividend = DIV_W'(rd_diff[H_W-1:0]) * DIV_W'(GLYPH_TOP);
    greq.divisor  = hm_eff;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          col_d    = in_word_i.col;
          row_d    = in_word_i.row;
          drop_d   = in_word_i.drop_enable;
          inside_d = in_inside;
          pend_d   = '0;
          pend_d.done_res = 1'b1;
          case (in_op)
            OP_LOAD: begin
              cur_we  = in_inside && !in_word_i.load_other;
              prev_we = in_inside && in_word_i.load_other;
              state_d = S_FIN;
            end
            OP_STEP: begin
              flag_d  = ~flag_q;
              state_d = S_SETUP;
            end
            OP_READ: begin
              cur_re  = 1'b1;
              state_d = S_RD0;
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_SETUP: state_d = S_DROP;
      S_DROP: begin
        cur_we    = drop_q && inside_q;
        cur_waddr = {row_q, col_q};
        cur_wdata = {1'b0, thr.p90};
        i_d       = COL_W'(1);
        j_d       = ROW_W'(1);
        ph_d      = 2'd0;
        state_d   = S_WALK;
      end
      S_WALK: begin
        prev_re   = 1'b1;
        cur_re    = (ph_q == 2'd0);
        cur_raddr = {j_q, i_q};
        case (ph_q)
          2'd0:    prev_raddr = {j_q, i_q - COL_W'(1)};
          2'd1:    prev_raddr = {j_q, i_q + COL_W'(1)};
          2'd2:    prev_raddr = {j_q - ROW_W'(1), i_q};
          default: prev_raddr = {j_q + ROW_W'(1), i_q};
        endcase
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd3) begin
          if (i_q == last_i) begin
            i_d = COL_W'(1);
            j_d = j_q + ROW_W'(1);
            if (j_q == last_j) begin
              state_d = S_DRAIN;
            end
          end else begin
            i_d = i_q + COL_W'(1);
          end
        end
      end
      S_DRAIN: state_d = S_FIN;
      S_RD0: begin
        s_d        = cur_rdata;
        greq.start = 1'b1;
        state_d    = S_RD1;
      end
      S_RD1: begin
        if (grsp.done) begin
          if (inside_q) begin
            pend_d.height = s_q;
            if (above(s_q, thr.p80)) begin
              pend_d.color_band = 3'd0;
            end else if (above(s_q, thr.p60)) begin
              pend_d.color_band = 3'd1;
            end else if (above(s_q, thr.p40)) begin
              pend_d.color_band = 3'd2;
            end else if (above(s_q, thr.p20)) begin
              pend_d.color_band = 3'd3;
            end else begin
              pend_d.color_band = 3'd4;
            end
            pend_d.drawable    = s_draw;
            pend_d.glyph_level = s_draw ? grsp.level : '0;
          end
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          res_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (dv_q && dph_q == 2'd3) begin
      cur_we    = 1'b1;
      cur_waddr = daddr_q;
      cur_wdata = sat_h(nv);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      flag_q      <= 1'b0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      flag_q  <= flag_d;
      dv_q    <= (state_q == S_WALK);
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    col_d_hold: begin
      col_q    <= col_d;
      row_q    <= row_d;
      drop_q   <= drop_d;
      inside_q <= inside_d;
      i_q      <= i_d;
      j_q      <= j_d;
      ph_q     <= ph_d;
      s_q      <= s_d;
      pend_q   <= pend_d;
      dph_q    <= ph_q;
      daddr_q  <= {j_q, i_q};
    end
    if (dv_q) begin
      if (dph_q == 2'd0) begin
        acc_q  <= SUM_W'(signed'(prev_rdata));
        curv_q <= cur_rdata;
      end else begin
        acc_q <= sum;
      end
    end
    if (res_load) begin
      res_q <= pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = res_q;

  a_walk_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_q && dph_q == 2'd3) |->
      (daddr_q[COL_W-1:0] != '0) && (daddr_q[ADDR_W-1:COL_W] != '0))
    else $error("ripple write to edge cell");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |=> (state_q == S_FIN) && !dv_q)
    else $error("walk pipeline not empty after drain");

  a_prev_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK || dv_q) |-> !prev_we)
    else $error("previous grid written during step");

endmodule

`default_nettype wire
